// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the bank mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define ASSERT_SAME(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/mmc3bm_pkg.sv =====
// Types and constants shared by the multicart MMC3 bank mapper.
`timescale 1ns / 1ps
`default_nettype none

package mmc3bm_pkg;

  typedef enum logic [1:0] {
    OP_CPU_WRITE  = 2'd0,
    OP_PRG_LOOKUP = 2'd1,
    OP_CHR_LOOKUP = 2'd2
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] address;
    logic [7:0]  data;
  } in_req_t;

  typedef struct packed {
    logic [7:0] physical_bank;
    logic       handled;
  } out_rsp_t;

  // Slot value and outer select handed to the bank calculator.
  typedef struct packed {
    logic       is_chr;
    logic [7:0] slot;
    logic [2:0] outer;
  } bank_lookup_t;

  // Configuration register indexes.
  localparam logic CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic CFG_CHR_BANK_COUNT = 1'b1;

  localparam logic [5:0] PRG_COUNT_RESET = 6'd32;
  localparam logic [8:0] CHR_COUNT_RESET = 9'd256;

  // Controller register decode.
  localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
  localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
  localparam logic [15:0] OUTER_WIN_LOW   = 16'h6000;
  localparam logic [15:0] CHR_WIN_END     = 16'h2000;

  // Bank index codes of the bank select register.
  localparam logic [2:0] BIDX_CHR_PAIR0 = 3'd0;
  localparam logic [2:0] BIDX_CHR_PAIR1 = 3'd1;
  localparam logic [2:0] BIDX_PRG_SWAP  = 3'd6;
  localparam logic [2:0] BIDX_PRG_MID   = 3'd7;

endpackage

`default_nettype wire

// ===== rtl/multicart_mmc3_bank_mapper.sv =====
// Top level of the multicart MMC3 bank mapper: request pipeline, mapper state and result register.
//
// Usage: each request on the in_ channel is a CPU write (outer game select at 6000-7FFF,
// bank select at 8000, bank data at 8001), a PRG lookup (8000-FFFF) or a CHR lookup
// (0000-1FFF). Every request gives exactly one result on the out_ channel: the physical
// bank and a handled flag. Both channels use valid/stall; a request moves at an edge where
// valid is high and stall is low.
// A request accepted on in_ is registered in the input register, processed there against the
// mapper state and registered in the result register, from which out_ shows it.
// Throughput: one request per cycle while out_stall is low, set by the single pass through
// the input register and the result register; state writes and lookups act in request order
// in that pass. When the receiver stalls, the result register holds its request and the input
// register keeps the next one; in_stall rises only when both are occupied.
// Reset (synchronous, rst_n low) empties both registers and returns the mapper state:
// outer select, bank index and swap modes to zero, PRG slots to 0, 1, 30, 31, CHR slots
// to 0..7, and the bank counts to 32 PRG and 256 CHR banks.
// The cfg_ port writes the bank counts; it is meant to be used only while the block idles.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module multicart_mmc3_bank_mapper
  import mmc3bm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [8:0] cfg_wdata
);

  // Pipeline registers.
  logic     s1_valid_r, s1_valid_nxt;
  in_req_t  s1_req_r;
  logic     out_valid_r, out_valid_nxt;
  out_rsp_t out_rsp_r, out_rsp_nxt;

  // Configuration.
  logic [5:0] prg_count_r;
  logic [8:0] chr_count_r;

  // Mapper state.
  logic [2:0] outer_r, outer_nxt;
  logic [2:0] bank_index_r, bank_index_nxt;
  logic       prg_mode_r, prg_mode_nxt;
  logic       chr_mode_r, chr_mode_nxt;
  logic [7:0] prg_slot_r [4];
  logic [7:0] prg_slot_nxt [4];
  logic [7:0] chr_slot_r [8];
  logic [7:0] chr_slot_nxt [8];

  logic         out_free;
  logic         advance;
  logic         in_accept;
  logic [15:0]  reg_sel;
  logic [7:0]   fixed_bank;
  logic [7:0]   pair_base;
  logic [2:0]   rel_index;
  logic         new_prg_mode;
  logic         new_chr_mode;
  bank_lookup_t lookup;
  logic [7:0]   mapped_bank;

  // The result register frees up when empty or when its result is being taken.
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  // Lookup path: select the slot addressed by the request.
  always_comb begin
    lookup.is_chr = (s1_req_r.opcode == OP_CHR_LOOKUP);
    lookup.outer  = outer_r;
    if (lookup.is_chr) begin
      lookup.slot = chr_slot_r[s1_req_r.address[12:10]];
    end else begin
      lookup.slot = prg_slot_r[s1_req_r.address[14:13]];
    end
  end

  mmc3bm_bank_calc u_bank_calc (
    .lookup         (lookup),
    .prg_bank_count (prg_count_r),
    .chr_bank_count (chr_count_r),
    .physical_bank  (mapped_bank)
  );

  // Write path and result formation for the request in the input register.
  always_comb begin
    outer_nxt      = outer_r;
    bank_index_nxt = bank_index_r;
    prg_mode_nxt   = prg_mode_r;
    chr_mode_nxt   = chr_mode_r;
    for (int i = 0; i < 4; i++) begin
      prg_slot_nxt[i] = prg_slot_r[i];
    end
    for (int i = 0; i < 8; i++) begin
      chr_slot_nxt[i] = chr_slot_r[i];
    end
    out_rsp_nxt.physical_bank = 8'd0;
    out_rsp_nxt.handled       = 1'b0;

    reg_sel      = s1_req_r.address & REG_DECODE_MASK;
    fixed_bank   = {2'b00, prg_count_r} - 8'd2;
    pair_base    = {s1_req_r.data[7:1], 1'b0};
    rel_index    = bank_index_r - 3'd2;
    new_prg_mode = s1_req_r.data[6];
    new_chr_mode = s1_req_r.data[7];

    case (s1_req_r.opcode)
      OP_CPU_WRITE: begin
        if (s1_req_r.address[15]) begin
          if (reg_sel == REG_BANK_SELECT) begin
            out_rsp_nxt.handled = 1'b1;
            bank_index_nxt = s1_req_r.data[2:0];
            prg_mode_nxt   = new_prg_mode;
            chr_mode_nxt   = new_chr_mode;
            // A CHR mode change exchanges the 2KB half with the 1KB half.
            if (new_chr_mode != chr_mode_r) begin
              for (int i = 0; i < 4; i++) begin
                chr_slot_nxt[i]     = chr_slot_r[i + 4];
                chr_slot_nxt[i + 4] = chr_slot_r[i];
              end
            end
            // A PRG mode change moves the switchable slot and fixes the freed one.
            if (new_prg_mode != prg_mode_r) begin
              if (new_prg_mode) begin
                prg_slot_nxt[0] = fixed_bank;
                prg_slot_nxt[2] = prg_slot_r[0];
              end else begin
                prg_slot_nxt[0] = prg_slot_r[2];
                prg_slot_nxt[2] = fixed_bank;
              end
            end
          end else if (reg_sel == REG_BANK_DATA) begin
            out_rsp_nxt.handled = 1'b1;
            case (bank_index_r)
              BIDX_CHR_PAIR0: begin
                chr_slot_nxt[{chr_mode_r, 2'd0}] = pair_base;
                chr_slot_nxt[{chr_mode_r, 2'd1}] = pair_base + 8'd1;
              end
              BIDX_CHR_PAIR1: begin
                chr_slot_nxt[{chr_mode_r, 2'd2}] = pair_base;
                chr_slot_nxt[{chr_mode_r, 2'd3}] = pair_base + 8'd1;
              end
              BIDX_PRG_SWAP: begin
                prg_slot_nxt[{prg_mode_r, 1'b0}] = s1_req_r.data;
              end
              BIDX_PRG_MID: begin
                prg_slot_nxt[1] = s1_req_r.data;
              end
              default: begin
                chr_slot_nxt[{!chr_mode_r, rel_index[1:0]}] = s1_req_r.data;
              end
            endcase
          end
        end else if (s1_req_r.address >= OUTER_WIN_LOW) begin
          out_rsp_nxt.handled = 1'b1;
          outer_nxt = s1_req_r.data[2:0];
        end
      end
      OP_PRG_LOOKUP: begin
        if (s1_req_r.address[15]) begin
          out_rsp_nxt.handled       = 1'b1;
          out_rsp_nxt.physical_bank = mapped_bank;
        end
      end
      OP_CHR_LOOKUP: begin
        if (s1_req_r.address < CHR_WIN_END) begin
          out_rsp_nxt.handled       = 1'b1;
          out_rsp_nxt.physical_bank = mapped_bank;
        end
      end
      default: begin
        out_rsp_nxt.handled = 1'b0;
      end
    endcase
  end

  // Control and mapper state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      prg_count_r  <= PRG_COUNT_RESET;
      chr_count_r  <= CHR_COUNT_RESET;
      outer_r      <= 3'd0;
      bank_index_r <= 3'd0;
      prg_mode_r   <= 1'b0;
      chr_mode_r   <= 1'b0;
      prg_slot_r[0] <= 8'd0;
      prg_slot_r[1] <= 8'd1;
      prg_slot_r[2] <= {2'b00, PRG_COUNT_RESET} - 8'd2;
      prg_slot_r[3] <= {2'b00, PRG_COUNT_RESET} - 8'd1;
      for (int i = 0; i < 8; i++) begin
        chr_slot_r[i] <= 8'(i);
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_PRG_BANK_COUNT) begin
          prg_count_r <= cfg_wdata[5:0];
        end else begin
          chr_count_r <= cfg_wdata;
        end
      end
      if (advance) begin
        outer_r      <= outer_nxt;
        bank_index_r <= bank_index_nxt;
        prg_mode_r   <= prg_mode_nxt;
        chr_mode_r   <= chr_mode_nxt;
        for (int i = 0; i < 4; i++) begin
          prg_slot_r[i] <= prg_slot_nxt[i];
        end
        for (int i = 0; i < 8; i++) begin
          chr_slot_r[i] <= chr_slot_nxt[i];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r <= in_req;
    end
    if (advance) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  // The input side only stalls while a request waits behind a blocked result.
  `ASSERT_SAME(a_stall_needs_pending, clk, rst_n, in_stall, s1_valid_r && out_valid_r, "in_stall without pending requests")

  // A request leaving the input register shows up as a result in the next cycle.
  `ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, out_valid_r, "advanced request lost")

  // Unhandled requests and writes never carry a bank number.
  `ASSERT_SAME(a_unhandled_zero_bank, clk, rst_n, out_valid_r && !out_rsp_r.handled, out_rsp_r.physical_bank == 8'd0, "unhandled result with nonzero bank")

endmodule

`default_nettype wire

// ===== rtl/mmc3bm_bank_calc.sv =====
// Physical bank calculation: outer game bits merged with a slot value, then wrapped.
`timescale 1ns / 1ps
`default_nettype none

module mmc3bm_bank_calc
  import mmc3bm_pkg::*;
(
  input  bank_lookup_t lookup,
  input  logic [5:0]   prg_bank_count,
  input  logic [8:0]   chr_bank_count,
  output logic [7:0]   physical_bank
);

  logic [4:0] prg_raw;
  logic [5:0] prg_mask;
  logic [4:0] prg_bank;
  logic [7:0] chr_raw;
  logic [8:0] chr_mask;
  logic [7:0] chr_bank;

  always_comb begin
    // Outer bit 2 picks the upper 128KB; outer bits 1:0 both set pick a 64KB half.
    prg_raw = {lookup.outer[2],
               (lookup.outer[1:0] == 2'b11) | (lookup.slot[3] & lookup.outer[2]),
               lookup.slot[2:0]};
    prg_mask = prg_bank_count - 6'd1;
    if ({1'b0, prg_raw} > prg_mask) begin
      prg_bank = prg_raw & prg_mask[4:0];
    end else begin
      prg_bank = prg_raw;
    end

    chr_raw  = {lookup.outer[2], lookup.slot[6:0]};
    chr_mask = chr_bank_count - 9'd1;
    if ({1'b0, chr_raw} > chr_mask) begin
      chr_bank = chr_raw & chr_mask[7:0];
    end else begin
      chr_bank = chr_raw;
    end

    physical_bank = lookup.is_chr ? chr_bank : {3'b000, prg_bank};
  end

endmodule

`default_nettype wire
